@@ rtl/assert_macros.svh @@
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spd assertion failed");

// checked at every edge, reset included
`define SPD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("spd assertion failed");

`endif

@@ rtl/spd_pkg.sv @@
// Package for the seven-point peak detector: types, constants, register map
package spd_pkg;
    localparam int          MAX_SAMPLES_DEF = 4096;
    localparam logic [31:0] PEAK_TH_RST     = 32'd327680;
    localparam logic [31:0] SLOPE_TH_RST    = 32'd98304;
    localparam logic [31:0] SLOPE_SAT       = 32'hFFFF_FFFF;
    localparam int          DIV_STEPS       = 49;

    localparam logic REG_PEAK_TH  = 1'b0;
    localparam logic REG_SLOPE_TH = 1'b1;

    // candidate handed from front to back: window points 1..5, center is entry 2
    typedef struct packed {
        logic [11:0]      idx;
        logic [4:0][31:0] val;
        logic [4:0][31:0] wl;
    } t_cand;
endpackage

@@ rtl/seven_point_peak_detector.sv @@
// Top level of the seven-point peak detector with its register port
//  channel   | dir | handshake                | payload
//  sample    | in  | i_valid / o_ready        | value, wavelength, end_of_spectrum
//  peak      | out | o_peak_valid / i_peak_ready | index, value, wavelength
//  config    | in  | psel, penable, pwrite    | paddr, pwdata, prdata
// Samples enter at one per cycle while the two-entry candidate queue has room.
// Each candidate takes 4 slopes through the serial divider, each with a setup
// step, up to 49 quotient steps and an accumulate step.
// Synchronous active-low reset clears window, count, queue and output valid.
// A full queue drops o_ready; a held peak word stalls the back end, then the queue fills.
module seven_point_peak_detector #(
    parameter int MAX_SAMPLES = spd_pkg::MAX_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_sample_wavelength,
    input  logic               i_end_of_spectrum,
    output logic               o_peak_valid,
    input  logic               i_peak_ready,
    output logic [11:0]        o_peak_index,
    output logic signed [31:0] o_peak_value,
    output logic [31:0]        o_peak_wavelength,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [31:0]    r_peak_th, r_slope_th;
    logic           q_full, q_ne, push, pop;
    spd_pkg::t_cand cand_in, cand_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == spd_pkg::REG_SLOPE_TH) ? r_slope_th : r_peak_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_th  <= spd_pkg::PEAK_TH_RST;
            r_slope_th <= spd_pkg::SLOPE_TH_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                spd_pkg::REG_PEAK_TH:  r_peak_th  <= pwdata;
                spd_pkg::REG_SLOPE_TH: r_slope_th <= pwdata;
                default: begin
                end
            endcase
        end
    end

    spd_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sample_value      (i_sample_value),
        .i_sample_wavelength (i_sample_wavelength),
        .i_end_of_spectrum   (i_end_of_spectrum),
        .i_peak_th           (r_peak_th),
        .i_q_full            (q_full),
        .o_push              (push),
        .o_cand              (cand_in)
    );

    spd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cand     (cand_in),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_ne),
        .o_cand     (cand_out)
    );

    spd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_nonempty      (q_ne),
        .i_cand            (cand_out),
        .o_pop             (pop),
        .i_slope_th        (r_slope_th),
        .o_peak_valid      (o_peak_valid),
        .i_peak_ready      (i_peak_ready),
        .o_peak_index      (o_peak_index),
        .o_peak_value      (o_peak_value),
        .o_peak_wavelength (o_peak_wavelength)
    );
endmodule

@@ rtl/spd_front.sv @@
// Front end: sample window, sample count and peak candidate classification
module spd_front #(
    parameter int MAX_SAMPLES = spd_pkg::MAX_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_sample_value,
    input  logic [31:0]        i_sample_wavelength,
    input  logic               i_end_of_spectrum,
    input  logic [31:0]        i_peak_th,
    input  logic               i_q_full,
    output logic               o_push,
    output spd_pkg::t_cand     o_cand
);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [5:0][31:0] r_val, n_val;
    logic [5:0][31:0] r_wl, n_wl;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             acc, live, cand;
    logic [11:0]      cnt12;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && !i_q_full;
    assign live    = r_cnt < CW'(MAX_SAMPLES);
    assign cnt12   = 12'(r_cnt);

    assign cand = live && (r_cnt >= CW'(6))
        && ($signed(r_val[3]) > $signed(r_val[2]))
        && ($signed(r_val[2]) > $signed(r_val[1]))
        && ($signed(r_val[1]) > $signed(r_val[0]))
        && ($signed(r_val[3]) > $signed(r_val[4]))
        && ($signed(r_val[4]) > $signed(r_val[5]))
        && ($signed(r_val[5]) > i_sample_value)
        && ($signed(r_val[3]) > $signed(i_peak_th));

    assign o_push      = acc && cand;
    assign o_cand.idx  = cnt12 - 12'd3;
    assign o_cand.val  = r_val[5:1];
    assign o_cand.wl   = r_wl[5:1];

    always_comb begin
        n_val = r_val;
        n_wl  = r_wl;
        n_cnt = r_cnt;
        if (acc) begin
            if (live) begin
                n_val = {i_sample_value, r_val[5:1]};
                n_wl  = {i_sample_wavelength, r_wl[5:1]};
                n_cnt = r_cnt + CW'(1);
            end
            if (i_end_of_spectrum) begin
                n_val = '0;
                n_wl  = '0;
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_wl  <= '0;
            r_cnt <= '0;
        end else begin
            r_val <= n_val;
            r_wl  <= n_wl;
            r_cnt <= n_cnt;
        end
    end
endmodule

@@ rtl/spd_queue.sv @@
// Two-entry candidate queue between front and back
module spd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spd_pkg::t_cand i_cand,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output spd_pkg::t_cand o_cand
);
    spd_pkg::t_cand r_mem [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;

    assign o_full     = r_cnt == 2'd2;
    assign o_nonempty = r_cnt != 2'd0;
    assign o_cand     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

@@ rtl/spd_back.sv @@
// Back end: serial slope divider, slope sum, threshold test, output register
module spd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_nonempty,
    input  spd_pkg::t_cand     i_cand,
    output logic               o_pop,
    input  logic [31:0]        i_slope_th,
    output logic               o_peak_valid,
    input  logic               i_peak_ready,
    output logic [11:0]        o_peak_index,
    output logic signed [31:0] o_peak_value,
    output logic [31:0]        o_peak_wavelength
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_ACC    = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam int         DW        = spd_pkg::DIV_STEPS;
    localparam int         SW        = $clog2(DW);

    logic [2:0]     r_st, n_st;
    spd_pkg::t_cand r_c;
    logic [1:0]     r_k;
    logic [33:0]    r_sum;
    logic [31:0]    r_slope;
    logic [DW-1:0]  r_dvd;
    logic [31:0]    r_rem, r_adw;
    logic [SW-1:0]  r_step;

    logic signed [32:0] dv, dw;
    logic [32:0]        adv, adw33, t;
    logic               ge, out_free, pass;
    logic [2:0]         ka, kb;

    assign ka    = {1'b0, r_k};
    assign kb    = ka + 3'd1;
    assign dv    = $signed({r_c.val[kb][31], r_c.val[kb]})
                 - $signed({r_c.val[ka][31], r_c.val[ka]});
    assign dw    = $signed({1'b0, r_c.wl[kb]}) - $signed({1'b0, r_c.wl[ka]});
    assign adv   = dv[32] ? 33'(-dv) : 33'(dv);
    assign adw33 = dw[32] ? 33'(-dw) : 33'(dw);

    assign t  = {r_rem, r_dvd[DW-1]};
    assign ge = t >= {1'b0, r_adw};

    assign out_free = !o_peak_valid || i_peak_ready;
    assign pass     = r_sum >= {i_slope_th, 2'b00};
    assign o_pop    = (r_st == ST_IDLE) && i_q_nonempty;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (i_q_nonempty) n_st = ST_SETUP;
            ST_SETUP:  n_st = (adw33 == 33'd0) ? ST_ACC : ST_DIV;
            ST_DIV:    if (r_step == SW'(DW - 1)) n_st = ST_ACC;
            ST_ACC:    n_st = (r_k == 2'd3) ? ST_DECIDE : ST_SETUP;
            ST_DECIDE: if (!pass || out_free) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_c   <= i_cand;
                r_k   <= 2'd0;
                r_sum <= '0;
            end
            ST_SETUP: begin
                r_slope <= spd_pkg::SLOPE_SAT;
                r_dvd   <= {adv, 16'd0};
                r_rem   <= '0;
                r_adw   <= adw33[31:0];
                r_step  <= '0;
            end
            ST_DIV: begin
                r_rem  <= ge ? 32'(t - {1'b0, r_adw}) : t[31:0];
                r_dvd  <= {r_dvd[DW-2:0], ge};
                r_step <= r_step + SW'(1);
                if (r_step == SW'(DW - 1)) begin
                    r_slope <= (r_dvd[DW-2:31] != '0) ? spd_pkg::SLOPE_SAT
                                                      : {r_dvd[30:0], ge};
                end
            end
            ST_ACC: begin
                r_sum <= r_sum + {2'b00, r_slope};
                r_k   <= r_k + 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_st == ST_DECIDE) && pass && out_free) begin
            o_peak_index      <= r_c.idx;
            o_peak_value      <= r_c.val[2];
            o_peak_wavelength <= r_c.wl[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= ST_IDLE;
            o_peak_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if ((r_st == ST_DECIDE) && pass && out_free) begin
                o_peak_valid <= 1'b1;
            end else if (i_peak_ready) begin
                o_peak_valid <= 1'b0;
            end
        end
    end
endmodule

@@ rtl/spd_checker.sv @@
// Port-level checker for the seven-point peak detector, bound to the top level
`include "assert_macros.svh"

module spd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_peak_valid,
    input logic        i_peak_ready,
    input logic [11:0] o_peak_index,
    input logic [31:0] o_peak_value,
    input logic [31:0] o_peak_wavelength,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    `SPD_ASSERT(a_peak_hold, i_clk, i_rst_n,
        o_peak_valid && !i_peak_ready |=> o_peak_valid && $stable(o_peak_index)
        && $stable(o_peak_value) && $stable(o_peak_wavelength))
    `SPD_ASSERT_ALWAYS(a_rst_no_peak, i_clk, !i_rst_n |=> !o_peak_valid)
    `SPD_ASSERT_ALWAYS(a_pready, i_clk, pready)
    `SPD_ASSERT(a_cfg_readback, i_clk, i_rst_n,
        psel && penable && pwrite |=>
        (paddr[2] != $past(paddr[2])) || (prdata == $past(pwdata)))
endmodule

bind seven_point_peak_detector spd_checker u_spd_checker (.*);

@@ dv/tb_top.sv @@
// Testbench for the seven-point peak detector: directed and random sample streams
`timescale 1ns / 100ps
module tb_top;
    localparam int MAXS = spd_pkg::MAX_SAMPLES_DEF;
    localparam int LIMIT = 20000;

    typedef struct packed {
        logic [11:0] idx;
        logic [31:0] val;
        logic [31:0] wl;
    } t_peak;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_valid = 1'b0, o_ready;
    logic signed [31:0] i_sample_value = '0;
    logic [31:0] i_sample_wavelength = '0;
    logic i_end_of_spectrum = 1'b0;
    logic o_peak_valid, i_peak_ready = 1'b0;
    logic [11:0] o_peak_index;
    logic signed [31:0] o_peak_value;
    logic [31:0] o_peak_wavelength;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;

    seven_point_peak_detector u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] pk_th, sl_th;
    logic [31:0] vwin [6];
    logic [31:0] wwin [6];
    int unsigned scount;
    t_peak peaks_due [$];

    int errors, mism, n_words, n_peaks, idle_cyc, rx_gap;
    bit rx_idle_en = 1'b1, tx_idle_en = 1'b1, hold_rx = 1'b0;

    function automatic logic [31:0] slope_of(logic [31:0] va, logic [31:0] wa,
                                             logic [31:0] vb, logic [31:0] wb);
        longint dv, dw;
        logic [63:0] q;
        dv = longint'($signed(vb)) - longint'($signed(va));
        dw = longint'({1'b0, wb}) - longint'({1'b0, wa});
        if (dv < 0) dv = -dv;
        if (dw < 0) dw = -dw;
        if (dw == 0) return spd_pkg::SLOPE_SAT;
        q = (64'(dv) << 16) / 64'(dw);
        return (q > 64'hFFFF_FFFF) ? spd_pkg::SLOPE_SAT : q[31:0];
    endfunction

    task automatic clear_win();
        for (int i = 0; i < 6; i++) begin
            vwin[i] = '0;
            wwin[i] = '0;
        end
        scount = 0;
    endtask

    task automatic predict_peak(logic [31:0] cv, logic [31:0] cw, logic e);
        logic [31:0] v [7];
        logic [31:0] w [7];
        logic [63:0] sum;
        t_peak p;
        if (scount < MAXS) begin
            for (int i = 0; i < 6; i++) begin
                v[i] = vwin[i];
                w[i] = wwin[i];
            end
            v[6] = cv;
            w[6] = cw;
            if (scount >= 6 && $signed(v[3]) > $signed(v[2]) &&
                $signed(v[2]) > $signed(v[1]) && $signed(v[1]) > $signed(v[0]) &&
                $signed(v[3]) > $signed(v[4]) && $signed(v[4]) > $signed(v[5]) &&
                $signed(v[5]) > $signed(v[6]) && $signed(v[3]) > $signed(pk_th)) begin
                sum = 64'(slope_of(v[4], w[4], v[5], w[5])) +
                      64'(slope_of(v[3], w[3], v[4], w[4])) +
                      64'(slope_of(v[2], w[2], v[3], w[3])) +
                      64'(slope_of(v[1], w[1], v[2], w[2]));
                if (sum >= (64'(sl_th) << 2)) begin
                    p.idx = 12'(scount - 3);
                    p.val = v[3];
                    p.wl = w[3];
                    peaks_due.insert(peaks_due.size(), p);
                end
            end
            for (int i = 0; i < 6; i++) begin
                vwin[i] = v[i + 1];
                wwin[i] = w[i + 1];
            end
            scount++;
        end
        if (e) clear_win();
    endtask

    // sender of one sample word; valid stays up between back-to-back words
    task automatic send_sample(logic [31:0] v, logic [31:0] w, logic e);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_value <= v;
        i_sample_wavelength <= w;
        i_end_of_spectrum <= e;
        do @(posedge i_clk); while (!o_ready);
        predict_peak(v, w, e);
        n_words++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] d);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'(4 * spd_pkg::REG_PEAK_TH)) pk_th = d; else sl_th = d;
    endtask

    task automatic drain();
        int c = 0;
        i_valid <= 1'b0;
        while (peaks_due.size() != 0 && c < 200000) begin
            @(negedge i_clk);
            c++;
        end
        repeat (1000) @(negedge i_clk);
    endtask

    // receiver with random stalls
    always @(negedge i_clk) begin
        if (hold_rx) begin
            i_peak_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            i_peak_ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            i_peak_ready <= 1'b0;
            rx_gap <= $urandom_range(0, 2);
        end else begin
            i_peak_ready <= 1'b1;
        end
    end

    // peak checker
    always @(posedge i_clk) begin
        t_peak e;
        if (i_rst_n && o_peak_valid && i_peak_ready) begin
            n_peaks++;
            if (peaks_due.size() == 0) begin
                errors++;
                if (mism++ < 10) $display("unexpected peak idx=%0d", o_peak_index);
            end else begin
                e = peaks_due.pop_front();
                if (e.idx !== o_peak_index || e.val !== o_peak_value ||
                    e.wl !== o_peak_wavelength) begin
                    errors++;
                    if (mism++ < 10)
                        $display("peak mismatch exp %0d %h %h got %0d %h %h", e.idx,
                                 e.val, e.wl, o_peak_index, o_peak_value,
                                 o_peak_wavelength);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_peak_valid && i_peak_ready) || !i_rst_n)
            idle_cyc <= 0;
        else if (i_valid || peaks_due.size() != 0) begin
            idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= LIMIT) begin
                $display("watchdog timeout");
                $display("status: fail");
                $finish;
            end
        end
    end

    // one peak at index base+3 with given center, rise and wavelength step
    task automatic send_peak_run(int cen, int stp, int wstp, logic [31:0] w0);
        for (int i = 0; i < 7; i++)
            send_sample(cen - stp * ((i < 3) ? (3 - i) : (i - 3)),
                        w0 + wstp * i, 1'b0);
    endtask

    task automatic test_directed();
        send_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 32'h0, 1'b1);
        send_peak_run(32'h000A_0000, 32'h0001_0000, 32'h0001_0000, 32'h0010_0000);
        send_peak_run(32'h000A_0000, 32'h0001_0000, 0, 32'h0);
        send_sample(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h0, 1'b0);
        send_sample(32'h8000_0001, 32'h1, 1'b1);
        drain();
    endtask

    task automatic test_config();
        write_reg(3'(4 * spd_pkg::REG_PEAK_TH), 32'h8000_0000);
        write_reg(3'(4 * spd_pkg::REG_SLOPE_TH), 32'h0);
        send_peak_run(-32'sd100, 7, 1, 32'h1);
        send_sample(0, 0, 1'b1);
        drain();
        write_reg(3'(4 * spd_pkg::REG_PEAK_TH), 32'h7FFF_FFFF);
        write_reg(3'(4 * spd_pkg::REG_SLOPE_TH), 32'hFFFF_FFFF);
        send_peak_run(32'h4000_0000, 32'h1000_0000, 0, 32'h5);
        send_sample(0, 0, 1'b1);
        drain();
        write_reg(3'(4 * spd_pkg::REG_PEAK_TH), 32'h0);
        write_reg(3'(4 * spd_pkg::REG_SLOPE_TH), 32'hFFFF_FFFF);
        send_peak_run(32'h4000_0000, 32'h1000_0000, 0, 32'h5);
        send_sample(0, 0, 1'b1);
        drain();
        write_reg(3'(4 * spd_pkg::REG_PEAK_TH), spd_pkg::PEAK_TH_RST);
        write_reg(3'(4 * spd_pkg::REG_SLOPE_TH), spd_pkg::SLOPE_TH_RST);
    endtask

    task automatic test_random(int n);
        int k = 0;
        while (k < n) begin
            if ($urandom_range(0, 9) < 7) begin
                send_peak_run($urandom_range(0, 32'h0100_0000),
                              $urandom_range(1, 32'h0004_0000),
                              $urandom_range(0, 32'h0002_0000), $urandom);
                k += 7;
            end else begin
                send_sample($urandom, $urandom, $urandom_range(0, 19) == 0);
                k++;
            end
            if ($urandom_range(0, 7) == 0) begin
                send_sample($urandom, $urandom, 1'b1);
                k++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_rx = 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++)
                    send_peak_run(32'h0040_0000, 32'h0001_0000, 32'h100, 32'h0);
            end
            begin
                repeat (3000) @(negedge i_clk);
                hold_rx = 1'b0;
            end
        join
        send_sample(0, 0, 1'b1);
        drain();
    endtask

    initial begin
        pk_th = spd_pkg::PEAK_TH_RST;
        sl_th = spd_pkg::SLOPE_TH_RST;
        clear_win();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config();
        test_backpressure();
        test_random(1000);
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        test_random(200);
        send_sample(0, 0, 1'b1);
        drain();
        $display("%0d sample words sent, %0d peaks checked, %0d errors", n_words,
                 n_peaks, errors);
        $display("covered extremes, thresholds, a long output stall, random spectra");
        if (errors == 0 && peaks_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/spd_pkg.sv
rtl/spd_front.sv
rtl/spd_queue.sv
rtl/spd_back.sv
rtl/seven_point_peak_detector.sv
rtl/spd_checker.sv
dv/tb_top.sv
